>>> hw/rtl/sha256_stream_hasher_assert.svh
// ----------------------------------------------------------------------------
// SHA-256 stream hasher assertion macros
// Shared wrappers for concurrent assertions, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_ASSERT_SVH
`define SHA256_STREAM_HASHER_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define SHA_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// A condition that must hold in the cycle after the trigger.
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/sha_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash values, queue entry type and the round
// functions shared by the front end and the compression core.
// ----------------------------------------------------------------------------
`default_nettype none

package sha_pkg;

  // One message schedule word on its way from the front end to the core.
  typedef struct packed {
    logic        msg_end;  // last word of the last block of a message
    logic [31:0] word;
  } sha_entry_t;

  localparam logic [7:0] PadMark    = 8'h80;
  localparam logic [3:0] LenHiWord  = 4'd14;
  localparam logic [3:0] LenLoWord  = 4'd15;
  localparam logic [2:0] LastDigest = 3'd7;

  localparam logic [31:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Compression function: rotations by 2, 13 and 22.
  function automatic logic [31:0] big_sigma0(logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  // Compression function: rotations by 6, 11 and 25.
  function automatic logic [31:0] big_sigma1(logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  // Message schedule: rotations by 7 and 18, shift by 3.
  function automatic logic [31:0] small_sigma0(logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  // Message schedule: rotations by 17 and 19, shift by 10.
  function automatic logic [31:0] small_sigma1(logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Hashes a byte stream and returns the eight digest words per message.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel takes one request per cycle while s_tready_o is high:
// s_tdata_i is the message byte, s_tuser_i says whether the byte is present,
// and s_tlast_i ends the message after that byte. A request with neither
// byte nor end is a no-op. Bytes are packed into words and queued
// (QueueDepth words) ahead of the compression core, which runs one round per
// cycle while fed. Each block is gathered from bytes, passes the queue, runs
// through the rounds and is folded in by a chaining add. At the end of a
// message the front end inserts 3 to 18 padding and length words, one per
// cycle while the queue has room. The master channel then carries the eight
// digest words, most significant first, with the index on m_tuser_o and
// m_tlast_o on the eighth. A stalled receiver holds the core on the current
// word; the front end keeps taking bytes until the queue fills.
// Reset returns the chaining value to the initial hash and clears the
// length count; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sha256_stream_hasher_assert.svh"

module sha256_stream_hasher
  import sha_pkg::*;
#(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid_i,
  output logic             s_tready_o,
  input  wire logic [7:0]  s_tdata_i,   // [7:0] data_byte
  input  wire logic        s_tuser_i,   // [0] byte_valid
  input  wire logic        s_tlast_i,
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  output logic [31:0]      m_tdata_o,   // [31:0] digest_word
  output logic [2:0]       m_tuser_o,   // [2:0] word_index
  output logic             m_tlast_o
);

  logic       q_push, q_full, q_pop, q_valid;
  sha_entry_t q_wr_entry, q_rd_entry;

  sha_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_tvalid_i),
    .in_ready_o   (s_tready_o),
    .data_byte_i  (s_tdata_i),
    .byte_valid_i (s_tuser_i),
    .last_i       (s_tlast_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_entry_o    (q_wr_entry)
  );

  sha_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_wr_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_rd_entry)
  );

  sha_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_entry_i  (q_rd_entry),
    .pop_o       (q_pop),
    .out_valid_o (m_tvalid_o),
    .out_ready_i (m_tready_i),
    .out_word_o  (m_tdata_o),
    .out_index_o (m_tuser_o),
    .out_last_o  (m_tlast_o)
  );

  // The end-of-digest flag only rides on the final word.
  `SHA_ASSERT_ALWAYS(a_last_on_final, clk_i, rst_ni, !(m_tvalid_o && m_tlast_o) || (m_tuser_o == LastDigest), "digest end flag off the final word")

  // The front end never takes a request that could overrun the queue.
  `SHA_ASSERT_ALWAYS(a_ready_room, clk_i, rst_ni, !s_tready_o || !q_full, "request taken with the queue full")

  // Digest words follow one another without a gap and in order.
  `SHA_ASSERT_NEXT(a_digest_burst, clk_i, rst_ni, m_tvalid_o && m_tready_i && !m_tlast_o, m_tvalid_o && (m_tuser_o == $past(m_tuser_o) + 3'd1), "digest words out of sequence")

endmodule

`default_nettype wire

>>> hw/rtl/sha_front.sv
// ----------------------------------------------------------------------------
// SHA-256 front end
// Packs message bytes into big-endian words, counts the message length and
// generates the padding and length words at the end of a message.
// ----------------------------------------------------------------------------
`default_nettype none

module sha_front
  import sha_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       byte_valid_i,
  input  wire logic       last_i,
  input  wire logic       q_full_i,
  output logic            q_push_o,
  output sha_entry_t      q_entry_o
);

  typedef enum logic [1:0] {
    FrAccept = 2'b01,
    FrPad    = 2'b10
  } fr_state_e;

  fr_state_e   state_q, state_d;
  logic [5:0]  fill_q, fill_d;     // byte position within the block
  logic [31:0] acc_q, acc_d;       // partial word being gathered
  logic [63:0] bits_q, bits_d;     // message length in bits
  logic        mark_q, mark_d;     // pad mark already sent
  logic        second_q, second_d; // length goes into the following block
  logic [3:0]  wpos;
  logic [31:0] mark_word;

  assign wpos       = fill_q[5:2];
  assign in_ready_o = (state_q == FrAccept) && !q_full_i;

  // Word that carries the pad mark after the bytes already gathered.
  always_comb begin
    case (fill_q[1:0])
      2'd0: mark_word = {PadMark, 24'h0};
      2'd1: mark_word = {acc_q[31:24], PadMark, 16'h0};
      2'd2: mark_word = {acc_q[31:16], PadMark, 8'h0};
      default: mark_word = {acc_q[31:8], PadMark};
    endcase
  end

  // Byte gathering and the padding sequence.
  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    acc_d     = acc_q;
    bits_d    = bits_q;
    mark_d    = mark_q;
    second_d  = second_q;
    q_push_o  = 1'b0;
    q_entry_o = '0;
    case (state_q)
      FrAccept: begin
        if (in_valid_i && in_ready_o) begin
          if (byte_valid_i) begin
            case (fill_q[1:0])
              2'd0: acc_d[31:24] = data_byte_i;
              2'd1: acc_d[23:16] = data_byte_i;
              2'd2: acc_d[15:8]  = data_byte_i;
              default: acc_d[7:0] = data_byte_i;
            endcase
            if (fill_q[1:0] == 2'd3) begin
              q_push_o       = 1'b1;
              q_entry_o.word = {acc_q[31:8], data_byte_i};
            end
            fill_d = fill_q + 6'd1;
            bits_d = bits_q + 64'd8;
          end
          if (last_i) begin
            state_d  = FrPad;
            mark_d   = 1'b0;
            second_d = 1'b0;
          end
        end
      end
      FrPad: begin
        if (!q_full_i) begin
          q_push_o = 1'b1;
          if (!mark_q) begin
            q_entry_o.word = mark_word;
            mark_d         = 1'b1;
            // A mark in the next-to-last word leaves no room for the length.
            second_d       = (wpos == LenHiWord);
          end else if (!second_q && wpos == LenHiWord) begin
            q_entry_o.word = bits_q[63:32];
          end else if (!second_q && wpos == LenLoWord) begin
            q_entry_o.word    = bits_q[31:0];
            q_entry_o.msg_end = 1'b1;
          end
          if (second_q && wpos == LenLoWord) begin
            second_d = 1'b0;
          end
          fill_d = {wpos + 4'd1, 2'b00};
          if (q_entry_o.msg_end) begin
            state_d = FrAccept;
            fill_d  = '0;
            bits_d  = '0;
          end
        end
      end
      default: state_d = FrAccept;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= FrAccept;
      fill_q   <= '0;
      bits_q   <= '0;
      mark_q   <= 1'b0;
      second_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      bits_q   <= bits_d;
      mark_q   <= mark_d;
      second_q <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

endmodule

`default_nettype wire

>>> hw/rtl/sha_fifo.sv
// ----------------------------------------------------------------------------
// SHA-256 word queue
// Short first-in first-out queue of schedule words between the front end
// and the compression core.
// ----------------------------------------------------------------------------
`default_nettype none

module sha_fifo
  import sha_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire sha_entry_t entry_i,
  output logic            full_o,
  input  wire logic       pop_i,
  output logic            valid_o,
  output sha_entry_t      entry_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  sha_entry_t      mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/sha_core.sv
// ----------------------------------------------------------------------------
// SHA-256 compression core
// Runs one round per cycle while fed, with a rolling sixteen-word schedule, folds each
// block into the chaining value and hands out the digest word by word.
// ----------------------------------------------------------------------------
`default_nettype none

module sha_core
  import sha_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire sha_entry_t  in_entry_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      out_word_o,
  output logic [2:0]       out_index_o,
  output logic             out_last_o
);

  typedef enum logic [2:0] {
    CoRound = 3'b001,
    CoAdd   = 3'b010,
    CoOut   = 3'b100
  } co_state_e;

  co_state_e   state_q, state_d;
  logic [5:0]  rnd_q, rnd_d;
  logic [2:0]  idx_q, idx_d;
  logic        end_q, end_d;
  logic [31:0] v_q [8];
  logic [31:0] v_d [8];
  logic [31:0] chain_q [8];
  logic [31:0] chain_d [8];
  logic [31:0] sched_q [16];
  logic [31:0] sched_d [16];
  logic [31:0] wnext_q, wnext_d;
  logic        from_queue, step;
  logic [31:0] w_cur, t1, t2, ch, mj;

  // The first sixteen rounds take their word from the queue.
  assign from_queue = (rnd_q[5:4] == 2'b00);
  assign w_cur      = from_queue ? in_entry_i.word : wnext_q;
  assign step       = (state_q == CoRound) && (!from_queue || in_valid_i);
  assign pop_o      = (state_q == CoRound) && from_queue && in_valid_i;

  assign out_valid_o = (state_q == CoOut);
  assign out_word_o  = chain_q[idx_q];
  assign out_index_o = idx_q;
  assign out_last_o  = (idx_q == LastDigest);

  // Round function.
  assign ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t1 = v_q[7] + big_sigma1(v_q[4]) + ch + RoundK[rnd_q] + w_cur;
  assign t2 = big_sigma0(v_q[0]) + mj;

  // Next schedule word, computed one round ahead of its use.
  assign wnext_d = small_sigma1(sched_q[15]) + sched_q[10] +
                   small_sigma0(sched_q[2]) + sched_q[1];

  // Sequencer: rounds, chaining add and digest output.
  always_comb begin
    state_d = state_q;
    rnd_d   = rnd_q;
    idx_d   = idx_q;
    end_d   = end_q;
    v_d     = v_q;
    chain_d = chain_q;
    sched_d = sched_q;
    case (state_q)
      CoRound: begin
        if (step) begin
          v_d[7] = v_q[6];
          v_d[6] = v_q[5];
          v_d[5] = v_q[4];
          v_d[4] = v_q[3] + t1;
          v_d[3] = v_q[2];
          v_d[2] = v_q[1];
          v_d[1] = v_q[0];
          v_d[0] = t1 + t2;
          for (int i = 0; i < 15; i++) begin
            sched_d[i] = sched_q[i + 1];
          end
          sched_d[15] = w_cur;
          rnd_d = rnd_q + 6'd1;
          if (pop_o && rnd_q == 6'd15) begin
            end_d = in_entry_i.msg_end;
          end
          if (rnd_q == 6'd63) begin
            state_d = CoAdd;
          end
        end
      end
      CoAdd: begin
        for (int i = 0; i < 8; i++) begin
          chain_d[i] = chain_q[i] + v_q[i];
          v_d[i]     = chain_q[i] + v_q[i];
        end
        idx_d   = '0;
        state_d = end_q ? CoOut : CoRound;
      end
      CoOut: begin
        if (out_ready_i) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == LastDigest) begin
            chain_d = InitH;
            v_d     = InitH;
            end_d   = 1'b0;
            state_d = CoRound;
          end
        end
      end
      default: state_d = CoRound;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CoRound;
      rnd_q   <= '0;
      idx_q   <= '0;
      end_q   <= 1'b0;
      v_q     <= InitH;
      chain_q <= InitH;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
      idx_q   <= idx_d;
      end_q   <= end_d;
      v_q     <= v_d;
      chain_q <= chain_d;
    end
  end

  // Schedule window and look-ahead word.
  always_ff @(posedge clk_i) begin
    sched_q <= sched_d;
    if (step) begin
      wnext_q <= wnext_d;
    end
  end

endmodule

`default_nettype wire

>>> verif/sha256_stream_hasher_test.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Sends byte-stream messages through the slave channel and compares every
// digest word on the master channel against an in-bench SHA-256 model.
// Both channels idle in random bursts, and the receiver holds off long
// enough at least once to back the block up into its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha256_stream_hasher_test;

  localparam int unsigned ResetCycles  = 9;
  localparam int unsigned RandomItems  = 160;
  localparam int unsigned MinWords     = 24;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned DrainCycles  = 200;
  localparam int unsigned CycleLimit   = 200000;
  localparam logic [7:0]  PadByte      = 8'h80;
  localparam int unsigned LengthOffset = 56;

  localparam logic [31:0] StartHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // One digest word as it should leave the master channel.
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  // SHA-256 model of the hasher plus the digest words still owed by the block.
  class sha256_hash_model;
    logic [31:0]  chain_words [8];
    logic [7:0]   block_buf [64];
    int unsigned  block_fill;
    logic [63:0]  length_bits;
    logic [31:0]  sched_ring [16];
    digest_word_t pending_words [$];
    int unsigned  mismatches;
    int unsigned  messages_done;
    int unsigned  bytes_absorbed;
    int unsigned  words_compared;

    function new();
      mismatches     = 0;
      messages_done  = 0;
      bytes_absorbed = 0;
      words_compared = 0;
      for (int i = 0; i < 64; i++) block_buf[i] = 8'h00;
      for (int i = 0; i < 16; i++) sched_ring[i] = 32'h0;
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < 8; i++) chain_words[i] = StartHash[i];
      block_fill  = 0;
      length_bits = 64'h0;
    endfunction

    function logic [31:0] rotr(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    // Sixty-four rounds over block_buf with a rolling 16-word schedule.
    function void compress_block();
      logic [31:0] v [8];
      logic [31:0] w, s0, s1, ch, mj, t1, t2, a, b;
      for (int i = 0; i < 8; i++) v[i] = chain_words[i];
      for (int t = 0; t < 64; t++) begin
        if (t < 16) begin
          w = {block_buf[4*t], block_buf[4*t+1], block_buf[4*t+2], block_buf[4*t+3]};
        end else begin
          a  = sched_ring[(t - 15) & 15];
          b  = sched_ring[(t - 2) & 15];
          s0 = rotr(a, 7) ^ rotr(a, 18) ^ (a >> 3);
          s1 = rotr(b, 17) ^ rotr(b, 19) ^ (b >> 10);
          w  = sched_ring[t & 15] + s0 + sched_ring[(t - 7) & 15] + s1;
        end
        sched_ring[t & 15] = w;
        s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
        ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
        t1 = v[7] + s1 + ch + RoundConst[t] + w;
        s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
        mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
        t2 = s0 + mj;
        v[7] = v[6];
        v[6] = v[5];
        v[5] = v[4];
        v[4] = v[3] + t1;
        v[3] = v[2];
        v[2] = v[1];
        v[1] = v[0];
        v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain_words[i] = chain_words[i] + v[i];
    endfunction

    // Take one accepted request; an ending request pads and queues the digest.
    function void absorb_request(logic [7:0] data, logic has_byte, logic ends);
      digest_word_t entry;
      if (has_byte) begin
        block_buf[block_fill] = data;
        block_fill++;
        length_bits = length_bits + 64'd8;
        bytes_absorbed++;
        if (block_fill == 64) begin
          compress_block();
          block_fill = 0;
        end
      end
      if (!ends) return;

      // Pad mark, then zeros; the length spills into a second block if needed.
      block_buf[block_fill] = PadByte;
      block_fill++;
      if (block_fill > LengthOffset) begin
        while (block_fill < 64) begin
          block_buf[block_fill] = 8'h00;
          block_fill++;
        end
        compress_block();
        block_fill = 0;
      end
      while (block_fill < LengthOffset) begin
        block_buf[block_fill] = 8'h00;
        block_fill++;
      end
      for (int i = 0; i < 8; i++) block_buf[LengthOffset + i] = length_bits[63 - 8*i -: 8];
      compress_block();

      for (int i = 0; i < 8; i++) begin
        entry.word  = chain_words[i];
        entry.index = 3'(i);
        entry.last  = (i == 7);
        pending_words.push_back(entry);
      end
      messages_done++;
      restart();
    endfunction

    // Compare one accepted digest word with the oldest one owed.
    function void compare_digest_word(logic [31:0] word, logic [2:0] index, logic last);
      digest_word_t want;
      if (pending_words.size() == 0) begin
        mismatches++;
        $display("%0t: digest word %h (index %0d) arrived with none pending",
                 $time, word, index);
        return;
      end
      want = pending_words.pop_front();
      words_compared++;
      if (want.word !== word) begin
        mismatches++;
        $display("%0t: digest_word mismatch: expected %h, actual %h", $time, want.word, word);
      end
      if (want.index !== index) begin
        mismatches++;
        $display("%0t: word_index mismatch: expected %0d, actual %0d", $time, want.index, index);
      end
      if (want.last !== last) begin
        mismatches++;
        $display("%0t: last_word mismatch: expected %b, actual %b", $time, want.last, last);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] data_byte
  logic        s_tuser;   // [0] byte_valid
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // [31:0] digest_word
  logic [2:0]  m_tuser;   // [2:0] word_index
  logic        m_tlast;

  sha256_hash_model hash_model = new();

  bit          calm;
  int unsigned hold_asks = 0;
  int unsigned holds_done = 0;
  int unsigned requests_sent;
  int unsigned cycle_count = 0;

  sha256_stream_hasher i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .s_tvalid_i (s_tvalid),
    .s_tready_o (s_tready),
    .s_tdata_i  (s_tdata),
    .s_tuser_i  (s_tuser),
    .s_tlast_i  (s_tlast),
    .m_tvalid_o (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_o  (m_tdata),
    .m_tuser_o  (m_tuser),
    .m_tlast_o  (m_tlast)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d digest words pending",
               cycle_count, hash_model.pending_words.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Both handshakes are taken from the values present at the rising edge.
  always @(posedge clk) begin
    if (rst_n && s_tvalid && s_tready) hash_model.absorb_request(s_tdata, s_tuser, s_tlast);
    if (rst_n && m_tvalid && m_tready) hash_model.compare_digest_word(m_tdata, m_tuser, m_tlast);
  end

  // Receiver: random stall bursts, plus one long hold on request.
  initial begin
    m_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (holds_done < hold_asks) begin
        holds_done++;
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  // Offer one request and hold it until the block takes it.
  task automatic send_request(input logic [7:0] data, input logic has_byte, input logic ends);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= has_byte;
    s_tlast  <= ends;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (has_byte || ends) requests_sent++;
  endtask

  // One message of random bytes, with occasional ignored requests mixed in.
  task automatic send_message(input int unsigned len, input bit end_on_byte);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) send_request(8'($urandom), 1'b0, 1'b0);
      send_request(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
    end
    if (!end_on_byte || len == 0) send_request(8'($urandom), 1'b0, 1'b1);
  endtask

  // Stimulus and end of run.
  initial begin
    int unsigned random_start;
    int unsigned words_start;
    int unsigned msg_num;
    int unsigned len;
    bit          end_on_byte;

    calm         = 1'b0;
    requests_sent = 0;
    s_tvalid <= 1'b0;
    s_tdata  <= 8'h00;
    s_tuser  <= 1'b0;
    s_tlast  <= 1'b0;
    rst_n    <= 1'b0;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty message, ignored bytes, ending with and without a byte.
    send_request(8'hff, 1'b0, 1'b1);
    send_request(8'hff, 1'b0, 1'b0);
    send_request(8'h00, 1'b0, 1'b0);
    send_request(8'h61, 1'b1, 1'b0);
    send_request(8'h62, 1'b1, 1'b0);
    send_request(8'h63, 1'b1, 1'b1);
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'hff, 1'b1, 1'b0);
    send_request(8'haa, 1'b0, 1'b1);
    send_request(8'hff, 1'b1, 1'b1);
    send_request(8'h00, 1'b1, 1'b1);
    send_request(PadByte, 1'b1, 1'b0);
    send_request(8'h55, 1'b0, 1'b0);
    send_request(8'hff, 1'b0, 1'b1);

    // Random messages; the first few pin down the block and padding boundaries.
    random_start = requests_sent;
    words_start  = hash_model.messages_done * 8;
    msg_num      = 0;
    while (requests_sent - random_start < RandomItems ||
           hash_model.messages_done * 8 - words_start < MinWords) begin
      end_on_byte = 1'($urandom_range(0, 1));
      case (msg_num)
        0: len = 20;
        1: begin
          len = 64;
          end_on_byte = 1'b0;
        end
        2: len = 56;
        default: begin
          case ($urandom_range(0, 9))
            0, 1, 2: len = $urandom_range(0, 8);
            3:       len = $urandom_range(55, 57);
            4:       len = $urandom_range(63, 65);
            default: len = $urandom_range(9, 40);
          endcase
        end
      endcase
      send_message(len, end_on_byte);
      // The receiver holds off while the next message streams in.
      if (msg_num == 0) hold_asks++;
      msg_num++;
      if (msg_num >= 3 && requests_sent - random_start + 40 >= RandomItems) calm = 1'b1;
    end
    s_tvalid <= 1'b0;

    while (hash_model.pending_words.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Hashed %0d messages, %0d bytes in %0d requests; %0d receiver holds.",
             hash_model.messages_done, hash_model.bytes_absorbed, requests_sent, holds_done);
    $display("Compared %0d digest words, %0d mismatches.",
             hash_model.words_compared, hash_model.mismatches);
    if (hash_model.mismatches == 0 && hash_model.pending_words.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/sha_pkg.sv
hw/rtl/sha_front.sv
hw/rtl/sha_fifo.sv
hw/rtl/sha_core.sv
hw/rtl/sha256_stream_hasher.sv
verif/sha256_stream_hasher_test.sv
